### design/rfop_pkg.sv
// Shared types, codes and constants for the rectangle fill/outline painter.
package rfop_pkg;

  // Default canvas side and fraction bits of the rectangle coordinates
  localparam int unsigned MAX_SIDE_DEF  = 512;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Field widths of one input and one result word
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KIND_W  = 8;
  localparam int unsigned FIX_W   = 24;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned RC_W    = 9;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned IDX_W   = 2;

  // Packed input data: kind, left, top, w, h, colour, read row, read col
  localparam int unsigned IN_BITS   = KIND_W + 4 * FIX_W + COLOR_W + 2 * RC_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Signed width for rectangle bounds and scaled pixel positions
  // (covers 24-bit sums and a 1024-wide canvas with 16 fraction bits)
  localparam int unsigned COORD_W = 28;

  // Opcodes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PAINT = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BG     = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  // Rectangle kind bytes
  localparam logic [KIND_W-1:0] KIND_FILLED  = 8'h52;
  localparam logic [KIND_W-1:0] KIND_OUTLINE = 8'h72;

  // Reset values of the registers
  localparam logic [CFG_W-1:0]   WIDTH_RST = 10'd1;
  localparam logic [CFG_W-1:0]   HEIGHT_RST = 10'd1;
  localparam logic [COLOR_W-1:0] BG_RST    = 8'd32;

  // Pixel class from the classifier
  typedef enum logic [1:0] {
    CLS_OUT  = 2'd0,
    CLS_IN   = 2'd1,
    CLS_EDGE = 2'd2
  } cls_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SETUP  = 3'd1,
    ST_SWEEP  = 3'd2,
    ST_READ   = 3'd3,
    ST_FINISH = 3'd4
  } state_e;

  // Rectangle bounds prepared once per paint
  typedef struct packed {
    logic signed [COORD_W-1:0] x_lo;
    logic signed [COORD_W-1:0] x_hi;
    logic signed [COORD_W-1:0] x_lo_in;
    logic signed [COORD_W-1:0] x_hi_in;
    logic signed [COORD_W-1:0] y_lo;
    logic signed [COORD_W-1:0] y_hi;
    logic signed [COORD_W-1:0] y_lo_in;
    logic signed [COORD_W-1:0] y_hi_in;
  } bounds_t;

endpackage

### design/rectangle_fill_outline_painter.sv
// Top level: byte canvas with clear, rectangle paint and pixel read.
//
// Input words arrive on the s_axis channel: tuser carries the opcode
// (clear, paint rectangle, read pixel), tdata the rectangle, colour and
// read position. Each word yields exactly one result word on m_axis:
// tuser is the status bit (1 = invalid rectangle, nothing painted) and
// tdata the pixel byte (zero unless a read).
// Configuration (width, height, background byte) is written through the
// cfg_* port while the block is idle.
// Clear and paint sweep the rows x cols pixels in use, one pixel per
// cycle through a single classifier and the canvas RAM write port,
// passing the states setup, sweep and finish, where the result word is
// loaded into the output register once that is free. An invalid paint
// or an unused opcode goes straight to finish, an empty canvas skips
// the sweep, and a read passes the read state (one RAM read) first.
// s_axis_tready is high only while the sequencer is idle. A finished
// result waits in the output register, so a new word may be taken while
// m_axis_tready is held low; a second result then waits in the sequencer
// until the register drains.
// Reset clears the sequencer, the output register and the registers
// (width 1, height 1, background 0x20). Canvas contents stay undefined
// until a clear or a paint writes them; no clearing pass is run.
module rectangle_fill_outline_painter #(
  parameter int unsigned MAX_SIDE  = rfop_pkg::MAX_SIDE_DEF,
  parameter int unsigned FRAC_BITS = rfop_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [rfop_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [rfop_pkg::CFG_W-1:0]           cfg_data_i,
  // Input words
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // kind[7:0], left[31:8], top[55:32], w[79:56], h[103:80],
  // colour[111:104], read_row[120:112], read_col[129:121], zero pad
  input  logic [rfop_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // opcode[1:0]
  input  logic [rfop_pkg::OP_W-1:0]            s_axis_tuser,
  // Result words
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pixel_value[7:0]
  output logic [7:0]                           m_axis_tdata,
  // status[0]
  output logic                                 m_axis_tuser
);

  localparam int unsigned SIDE_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SIDE_CW = SIDE_W + 1;
  localparam int unsigned ADDR_W  = 2 * SIDE_W;
  localparam int unsigned DEPTH   = 1 << ADDR_W;
  localparam int unsigned FW      = rfop_pkg::FIX_W;
  localparam int unsigned CW      = rfop_pkg::COORD_W;

  // Input field positions in tdata
  localparam int unsigned KIND_LSB  = 0;
  localparam int unsigned LEFT_LSB  = KIND_LSB + rfop_pkg::KIND_W;
  localparam int unsigned TOP_LSB   = LEFT_LSB + FW;
  localparam int unsigned W_LSB     = TOP_LSB + FW;
  localparam int unsigned H_LSB     = W_LSB + FW;
  localparam int unsigned COLOR_LSB = H_LSB + FW;
  localparam int unsigned RROW_LSB  = COLOR_LSB + rfop_pkg::COLOR_W;
  localparam int unsigned RCOL_LSB  = RROW_LSB + rfop_pkg::RC_W;

  // ---------------------------------------------------------------
  // Configuration registers
  logic [rfop_pkg::CFG_W-1:0]   width_q, height_q;
  logic [rfop_pkg::COLOR_W-1:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rfop_pkg::WIDTH_RST;
      height_q <= rfop_pkg::HEIGHT_RST;
      bg_q     <= rfop_pkg::BG_RST;
    end else if (cfg_we_i) begin
      unique case (rfop_pkg::reg_e'(cfg_idx_i))
        rfop_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        rfop_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        rfop_pkg::REG_BG:     bg_q     <= cfg_data_i[rfop_pkg::COLOR_W-1:0];
        rfop_pkg::REG_NONE:   ;
        default:              ;
      endcase
    end
  end

  // Sides in use, clipped to the canvas store
  logic [10:0]        cols_full, rows_full;
  logic [SIDE_CW-1:0] cols_used, rows_used;
  logic               canvas_empty;

  assign cols_full = ({1'b0, width_q} > 11'(MAX_SIDE)) ? 11'(MAX_SIDE) : {1'b0, width_q};
  assign rows_full = ({1'b0, height_q} > 11'(MAX_SIDE)) ? 11'(MAX_SIDE) : {1'b0, height_q};
  assign cols_used = cols_full[SIDE_CW-1:0];
  assign rows_used = rows_full[SIDE_CW-1:0];
  assign canvas_empty = (cols_full == 11'd0) || (rows_full == 11'd0);

  // ---------------------------------------------------------------
  // Incoming word fields
  logic                              in_acc;
  rfop_pkg::op_e                     in_op;
  logic [rfop_pkg::KIND_W-1:0]       in_kind;
  logic signed [FW-1:0]              in_w, in_h;
  logic                              in_bad_rect;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_op   = rfop_pkg::op_e'(s_axis_tuser);
  assign in_kind = s_axis_tdata[KIND_LSB +: rfop_pkg::KIND_W];
  assign in_w    = $signed(s_axis_tdata[W_LSB +: FW]);
  assign in_h    = $signed(s_axis_tdata[H_LSB +: FW]);
  assign in_bad_rect = ((in_kind != rfop_pkg::KIND_FILLED) &&
                        (in_kind != rfop_pkg::KIND_OUTLINE)) ||
                       (in_w <= 0) || (in_h <= 0);

  // Word registers (payload, no reset)
  rfop_pkg::op_e                op_q;
  logic                         filled_q;
  logic                         bad_q;
  logic signed [FW-1:0]         x_q, y_q, w_q, h_q;
  logic [rfop_pkg::COLOR_W-1:0] color_q;
  logic [rfop_pkg::RC_W-1:0]    rd_row_q, rd_col_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= in_op;
      filled_q <= (in_kind == rfop_pkg::KIND_FILLED);
      bad_q    <= in_bad_rect;
      x_q      <= $signed(s_axis_tdata[LEFT_LSB +: FW]);
      y_q      <= $signed(s_axis_tdata[TOP_LSB +: FW]);
      w_q      <= in_w;
      h_q      <= in_h;
      color_q  <= s_axis_tdata[COLOR_LSB +: rfop_pkg::COLOR_W];
      rd_row_q <= s_axis_tdata[RROW_LSB +: rfop_pkg::RC_W];
      rd_col_q <= s_axis_tdata[RCOL_LSB +: rfop_pkg::RC_W];
    end
  end

  // ---------------------------------------------------------------
  // Rectangle bounds, worked out once in the setup cycle
  rfop_pkg::bounds_t            bounds_q, bounds_d;
  logic signed [CW-1:0]         one_fix, x_ext, y_ext, w_ext, h_ext;

  assign one_fix = $signed(CW'(1) << FRAC_BITS);
  assign x_ext   = CW'(x_q);
  assign y_ext   = CW'(y_q);
  assign w_ext   = CW'(w_q);
  assign h_ext   = CW'(h_q);

  always_comb begin
    bounds_d.x_lo    = x_ext;
    bounds_d.x_hi    = x_ext + w_ext;
    bounds_d.x_lo_in = x_ext + one_fix;
    bounds_d.x_hi_in = x_ext + w_ext - one_fix;
    bounds_d.y_lo    = y_ext;
    bounds_d.y_hi    = y_ext + h_ext;
    bounds_d.y_lo_in = y_ext + one_fix;
    bounds_d.y_hi_in = y_ext + h_ext - one_fix;
  end

  // ---------------------------------------------------------------
  // Sequencer
  rfop_pkg::state_e state_q, state_d;
  logic [SIDE_W-1:0] scan_row_q, scan_row_d, scan_col_q, scan_col_d;
  logic              last_col, last_row;
  logic              out_free;
  logic              load_out;
  logic              ram_we, ram_re;
  logic              in_range_q;
  rfop_pkg::cls_e    cls;

  assign last_col = ({1'b0, scan_col_q} == (cols_used - SIDE_CW'(1)));
  assign last_row = ({1'b0, scan_row_q} == (rows_used - SIDE_CW'(1)));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfop_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            rfop_pkg::OP_CLEAR: state_d = rfop_pkg::ST_SETUP;
            rfop_pkg::OP_PAINT: state_d = in_bad_rect ? rfop_pkg::ST_FINISH
                                                      : rfop_pkg::ST_SETUP;
            rfop_pkg::OP_READ:  state_d = rfop_pkg::ST_READ;
            rfop_pkg::OP_NOP:   state_d = rfop_pkg::ST_FINISH;
            default:            state_d = rfop_pkg::ST_FINISH;
          endcase
        end
      end
      rfop_pkg::ST_SETUP: begin
        state_d = canvas_empty ? rfop_pkg::ST_FINISH : rfop_pkg::ST_SWEEP;
      end
      rfop_pkg::ST_SWEEP: begin
        if (last_col && last_row) begin
          state_d = rfop_pkg::ST_FINISH;
        end
      end
      rfop_pkg::ST_READ: begin
        state_d = rfop_pkg::ST_FINISH;
      end
      rfop_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = rfop_pkg::ST_IDLE;
        end
      end
      default: state_d = rfop_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    load_out      = 1'b0;
    scan_row_d    = scan_row_q;
    scan_col_d    = scan_col_q;
    unique case (state_q)
      rfop_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      rfop_pkg::ST_SETUP: ;
      rfop_pkg::ST_SWEEP: begin
        if (op_q == rfop_pkg::OP_CLEAR) begin
          ram_we = 1'b1;
        end else begin
          ram_we = filled_q ? (cls != rfop_pkg::CLS_OUT) : (cls == rfop_pkg::CLS_EDGE);
        end
        // Column runs fastest; both wrap to zero at the end of the sweep
        if (last_col) begin
          scan_col_d = '0;
          scan_row_d = last_row ? '0 : scan_row_q + SIDE_W'(1);
        end else begin
          scan_col_d = scan_col_q + SIDE_W'(1);
        end
      end
      rfop_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      rfop_pkg::ST_FINISH: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rfop_pkg::ST_IDLE;
      scan_row_q <= '0;
      scan_col_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_row_q <= scan_row_d;
      scan_col_q <= scan_col_d;
    end
  end

  // Bounds and read range flag
  always_ff @(posedge clk_i) begin
    if (state_q == rfop_pkg::ST_SETUP) begin
      bounds_q <= bounds_d;
    end
    if (state_q == rfop_pkg::ST_READ) begin
      in_range_q <= ({2'b0, rd_row_q} < rows_full) && ({2'b0, rd_col_q} < cols_full);
    end
  end

  // ---------------------------------------------------------------
  // Shared pixel classifier
  rfop_classify #(
    .SIDE_W   (SIDE_W),
    .FRAC_BITS(FRAC_BITS)
  ) u_classify (
    .pix_row_i(scan_row_q),
    .pix_col_i(scan_col_q),
    .bounds_i (bounds_q),
    .cls_o    (cls)
  );

  // Canvas store, addressed {row, col}
  logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
  logic [rfop_pkg::COLOR_W-1:0] ram_wdata, ram_rdata;

  assign ram_waddr = {scan_row_q, scan_col_q};
  assign ram_raddr = {SIDE_W'(rd_row_q), SIDE_W'(rd_col_q)};
  assign ram_wdata = (op_q == rfop_pkg::OP_CLEAR) ? bg_q : color_q;

  rfop_ram #(
    .DATA_W(rfop_pkg::COLOR_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------
  // Output register
  logic                         m_valid_q;
  logic                         m_status_q, m_status_d;
  logic [rfop_pkg::COLOR_W-1:0] m_pix_q, m_pix_d;

  always_comb begin
    m_status_d = (op_q == rfop_pkg::OP_PAINT) && bad_q;
    m_pix_d    = ((op_q == rfop_pkg::OP_READ) && in_range_q) ? ram_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_status_q <= m_status_d;
      m_pix_q    <= m_pix_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = m_pix_q;

  // ---------------------------------------------------------------
  // Assertions

  // Canvas is written only during a sweep
  a_we_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == rfop_pkg::ST_SWEEP))
    else $error("canvas write outside sweep");

  // Sweep counters are back at zero whenever the sequencer is idle
  a_scan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rfop_pkg::ST_IDLE) |-> ((scan_row_q == '0) && (scan_col_q == '0)))
    else $error("scan counters not cleared after sweep");

  // A finished word with a free output register shows up on the next edge
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rfop_pkg::ST_FINISH) && out_free) |=>
      (m_axis_tvalid && (state_q == rfop_pkg::ST_IDLE)))
    else $error("finished word not presented");

  // An error status never carries a pixel byte
  a_status_no_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result with pixel data");

endmodule

### design/rfop_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfop_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/rfop_classify.sv
// Pixel classifier: places one pixel outside, inside or on the rectangle edge.
module rfop_classify #(
  parameter int unsigned SIDE_W    = 9,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic [SIDE_W-1:0]   pix_row_i,
  input  logic [SIDE_W-1:0]   pix_col_i,
  input  rfop_pkg::bounds_t   bounds_i,
  output rfop_pkg::cls_e      cls_o
);

  logic signed [rfop_pkg::COORD_W-1:0] pi;
  logic signed [rfop_pkg::COORD_W-1:0] pj;
  logic                                outside;
  logic                                edge_hit;

  // Scale the pixel position to the fixed-point grid
  assign pi = $signed(rfop_pkg::COORD_W'(pix_row_i) << FRAC_BITS);
  assign pj = $signed(rfop_pkg::COORD_W'(pix_col_i) << FRAC_BITS);

  // Closed rectangle test, then the one-unit band along the edges
  assign outside  = (pj < bounds_i.x_lo) || (pj > bounds_i.x_hi) ||
                    (pi < bounds_i.y_lo) || (pi > bounds_i.y_hi);
  assign edge_hit = (pj < bounds_i.x_lo_in) || (pj > bounds_i.x_hi_in) ||
                    (pi < bounds_i.y_lo_in) || (pi > bounds_i.y_hi_in);

  always_comb begin
    priority if (outside) begin
      cls_o = rfop_pkg::CLS_OUT;
    end else if (edge_hit) begin
      cls_o = rfop_pkg::CLS_EDGE;
    end else begin
      cls_o = rfop_pkg::CLS_IN;
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rectangle fill/outline painter: directed and random words.
module tb_top;

  localparam int unsigned SIDE = rfop_pkg::MAX_SIDE_DEF;
  localparam int unsigned FRAC = rfop_pkg::FRAC_BITS_DEF;
  localparam int QUIET_LIMIT = 1000000;

  // one input word together with the result it is predicted to give
  typedef struct packed {
    rfop_pkg::op_e                op;
    logic [rfop_pkg::KIND_W-1:0]  kind;
    logic [rfop_pkg::FIX_W-1:0]   left, top, w, h;
    logic [rfop_pkg::COLOR_W-1:0] color;
    logic [rfop_pkg::RC_W-1:0]    row, col;
    logic                         status;
    logic [7:0]                   pixel;
  } job_t;

  typedef struct packed {
    logic       status;
    logic [7:0] pixel;
  } result_t;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           cfg_we_i   = 1'b0;
  logic [rfop_pkg::IDX_W-1:0]     cfg_idx_i  = '0;
  logic [rfop_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // kind, left, top, w, h, colour, read_row, read_col, zero pad
  logic [rfop_pkg::IN_DATA_W-1:0] s_axis_tdata  = '0;
  // opcode
  logic [rfop_pkg::OP_W-1:0]      s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // pixel_value
  logic [7:0]                     m_axis_tdata;
  // status
  logic                           m_axis_tuser;

  // mirror of the canvas and of the registers
  logic [7:0]                 canvas_mirror [SIDE*SIDE];
  logic [rfop_pkg::CFG_W-1:0] width_cfg  = rfop_pkg::WIDTH_RST;
  logic [rfop_pkg::CFG_W-1:0] height_cfg = rfop_pkg::HEIGHT_RST;
  logic [7:0]                 bg_cfg     = rfop_pkg::BG_RST;

  job_t    words_queued [$];
  result_t results_due [$];
  job_t    word_out;
  result_t got_due;
  int      send_wait = 0, send_calm = 0;
  int      recv_wait = 0, recv_calm = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;

  rectangle_fill_outline_painter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // side in use: oversized values clip to the full canvas
  function automatic int side_used(logic [rfop_pkg::CFG_W-1:0] v);
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  // idle cycles before the next word, with calm stretches of none
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(5, 15);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic job_t mk(rfop_pkg::op_e op, logic [7:0] kind,
                              logic [23:0] left, top, w, h,
                              logic [7:0] color, logic [8:0] row, col);
    job_t j;
    j       = '0;
    j.op    = op;
    j.kind  = kind;
    j.left  = left;
    j.top   = top;
    j.w     = w;
    j.h     = h;
    j.color = color;
    j.row   = row;
    j.col   = col;
    return j;
  endfunction

  task automatic report(string what, int unsigned want, int unsigned got);
    $display("[tb] %s mismatch: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // canvas update and result of one word, in arrival order
  task automatic predict_word(inout job_t j);
    longint lx, ly, lw, lh, px, py, one;
    int     cols, rows, r, c;
    logic   in_rect, on_rim;
    cols = side_used(width_cfg);
    rows = side_used(height_cfg);
    lx   = {{40{j.left[23]}}, j.left};
    ly   = {{40{j.top[23]}}, j.top};
    lw   = {{40{j.w[23]}}, j.w};
    lh   = {{40{j.h[23]}}, j.h};
    one  = longint'(1) << FRAC;
    j.status = 1'b0;
    j.pixel  = 8'h00;
    case (j.op)
      rfop_pkg::OP_CLEAR: begin
        for (r = 0; r < rows; r++)
          for (c = 0; c < cols; c++)
            canvas_mirror[r*SIDE + c] = bg_cfg;
      end
      rfop_pkg::OP_PAINT: begin
        if ((j.kind != rfop_pkg::KIND_FILLED && j.kind != rfop_pkg::KIND_OUTLINE) ||
            lw <= 0 || lh <= 0) begin
          j.status = 1'b1;
        end else begin
          for (r = 0; r < rows; r++) begin
            py = longint'(r) << FRAC;
            for (c = 0; c < cols; c++) begin
              px      = longint'(c) << FRAC;
              in_rect = px >= lx && px <= lx + lw && py >= ly && py <= ly + lh;
              on_rim  = px < lx + one || px > lx + lw - one ||
                        py < ly + one || py > ly + lh - one;
              if (in_rect && (j.kind == rfop_pkg::KIND_FILLED || on_rim))
                canvas_mirror[r*SIDE + c] = j.color;
            end
          end
        end
      end
      rfop_pkg::OP_READ: begin
        if (j.row < rows && j.col < cols)
          j.pixel = canvas_mirror[int'(j.row)*SIDE + int'(j.col)];
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(job_t j);
    predict_word(j);
    words_queued.push_back(j);
  endtask

  // wait until the block is idle with nothing outstanding
  task automatic settle();
    @(negedge clk_i);
    while (words_queued.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(rfop_pkg::reg_e idx, logic [rfop_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      rfop_pkg::REG_WIDTH:  width_cfg  = val;
      rfop_pkg::REG_HEIGHT: height_cfg = val;
      rfop_pkg::REG_BG:     bg_cfg     = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // random words: mostly rectangles near the canvas and reads inside it
  task automatic queue_random(int count);
    job_t j;
    int   n, roll, cols, rows;
    cols = side_used(width_cfg);
    rows = side_used(height_cfg);
    for (n = 0; n < count; n++) begin
      j = mk(rfop_pkg::OP_NOP, 8'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
             24'($urandom), 8'($urandom), 9'($urandom), 9'($urandom));
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        j.op = rfop_pkg::OP_CLEAR;
      end else if (roll < 55) begin
        j.op = rfop_pkg::OP_PAINT;
        // below 14 the fields stay raw noise
        if (roll >= 14) begin
          j.kind = $urandom_range(0, 1) ? rfop_pkg::KIND_FILLED : rfop_pkg::KIND_OUTLINE;
          j.left = 24'($urandom_range(0, (cols + 8) * 256) - 1024);
          j.top  = 24'($urandom_range(0, (rows + 8) * 256) - 1024);
          j.w    = 24'($urandom_range(1, $urandom_range(0, 2) == 0 ? 767 : (cols + 4) * 256));
          j.h    = 24'($urandom_range(1, $urandom_range(0, 2) == 0 ? 767 : (rows + 4) * 256));
          if ($urandom_range(0, 11) == 0) j.w = 24'(-int'($urandom_range(0, 512)));
          if ($urandom_range(0, 11) == 0) j.h = 24'(-int'($urandom_range(0, 512)));
        end
      end else if (roll < 95) begin
        j.op = rfop_pkg::OP_READ;
        if ($urandom_range(0, 7) != 0) begin
          j.row = 9'($urandom_range(0, rows < 511 ? rows : 511));
          j.col = 9'($urandom_range(0, cols < 511 ? cols : 511));
        end
      end
      queue_word(j);
    end
  endtask

  // sender: one word at a time from the queue, random gaps between words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back({word_out.status, word_out.pixel});
        send_wait = draw_gap(send_calm);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (words_queued.size() != 0) begin
          word_out = words_queued.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= word_out.op;
          s_axis_tdata  <= rfop_pkg::IN_DATA_W'({word_out.col, word_out.row, word_out.color,
                                                 word_out.h, word_out.w, word_out.top,
                                                 word_out.left, word_out.kind});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result word, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          report("unexpected result", 0, int'({m_axis_tuser, m_axis_tdata}));
        end else begin
          got_due = results_due.pop_front();
          if (m_axis_tuser !== got_due.status)
            report("status", int'(got_due.status), int'(m_axis_tuser));
          if (m_axis_tdata !== got_due.pixel)
            report("pixel", int'(got_due.pixel), int'(m_axis_tdata));
        end
        recv_wait = draw_gap(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[rectangle_fill_outline_painter] ERROR");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    int ph;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: one pixel, background 0x20; first read lies outside
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd1, 9'd0));
    queue_word(mk(rfop_pkg::OP_NOP, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  8'hFF, 9'h1FF, 9'h1FF));
    queue_word(mk(rfop_pkg::OP_CLEAR, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_FILLED, 24'h0, 24'h0, 24'h100, 24'h100,
                  8'hA5, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    // invalid rectangles: bad kind, zero width, negative and minimum sizes
    queue_word(mk(rfop_pkg::OP_PAINT, 8'h00, 24'h0, 24'h0, 24'h100, 24'h100, 8'h01,
                  9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_FILLED, 24'h0, 24'h0, 24'h0, 24'h100,
                  8'h02, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_OUTLINE, 24'h0, 24'h0, 24'h100,
                  24'hFFFFFF, 8'h03, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_FILLED, 24'h0, 24'h0, 24'h800000,
                  24'h7FFFFF, 8'h04, 9'd0, 9'd0));
    // valid but far off the canvas
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_OUTLINE, 24'h7FFFFF, 24'h7FFFFF,
                  24'h7FFFFF, 24'h7FFFFF, 8'h3C, 9'd0, 9'd0));
    // outline whose centre pixel is inside but not on the rim
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_OUTLINE, 24'hFFFF00, 24'hFFFF00,
                  24'h200, 24'h200, 8'h11, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    settle();

    // oversized width clips to the full row
    write_reg(rfop_pkg::REG_WIDTH, 10'd1023);
    write_reg(rfop_pkg::REG_BG, 10'h000);
    queue_word(mk(rfop_pkg::OP_CLEAR, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_OUTLINE, 24'hFFFF80, 24'h0, 24'h00C880,
                  24'h100, 8'h5A, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd511));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd200));
    settle();

    // one column, full height
    write_reg(rfop_pkg::REG_WIDTH, 10'd1);
    write_reg(rfop_pkg::REG_HEIGHT, 10'd512);
    queue_word(mk(rfop_pkg::OP_CLEAR, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd511, 9'd0));
    settle();

    // empty canvas; a write to the unused index is dropped
    write_reg(rfop_pkg::REG_NONE, 10'h3FF);
    write_reg(rfop_pkg::REG_WIDTH, 10'd0);
    queue_word(mk(rfop_pkg::OP_CLEAR, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_FILLED, 24'h0, 24'h0, 24'h400, 24'h400,
                  8'h77, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    settle();

    // full canvas, one clear and one outline with fractional bounds
    write_reg(rfop_pkg::REG_WIDTH, 10'd512);
    write_reg(rfop_pkg::REG_BG, 10'h0FF);
    queue_word(mk(rfop_pkg::OP_CLEAR, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_PAINT, rfop_pkg::KIND_OUTLINE, 24'h000180, 24'h0000C0,
                  24'h01F000, 24'h01E840, 8'hC3, 9'd0, 9'd0));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00,
                  9'd511, 9'd511));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00, 9'd2, 9'd2));
    queue_word(mk(rfop_pkg::OP_READ, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00,
                  9'd100, 9'd100));

    // random phases on small canvases, each opened by a clear
    for (ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(rfop_pkg::REG_WIDTH, 10'($urandom_range(1, 24)));
      write_reg(rfop_pkg::REG_HEIGHT, 10'($urandom_range(1, 24)));
      write_reg(rfop_pkg::REG_BG, 10'($urandom_range(0, 255)));
      queue_word(mk(rfop_pkg::OP_CLEAR, 8'h00, 24'h0, 24'h0, 24'h0, 24'h0, 8'h00,
                    9'd0, 9'd0));
      queue_random(14);
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[rectangle_fill_outline_painter] OK");
    end else begin
      $display("[rectangle_fill_outline_painter] ERROR");
    end
    $finish;
  end

endmodule
